@@ rtl/lru_block_cache_core_defines.svh @@
// Assertion macros for the cache RTL
`ifndef LRU_BLOCK_CACHE_CORE_DEFINES_SVH
`define LRU_BLOCK_CACHE_CORE_DEFINES_SVH

// checked only out of reset
`define LBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lbc_pkg.sv @@
`timescale 1ns / 1ps
package lbc_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam int KEY_BITS   = 32;
  localparam int DATA_BITS  = 64;
  localparam int COUNT_BITS = 4;

  typedef struct packed {
    logic [1:0]           op;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] entry_count;
    logic [KEY_BITS-1:0]   evicted_key;
    logic                  evicted;
    logic [DATA_BITS-1:0]  data_out;
    logic                  hit;
  } rsp_t;

endpackage

@@ rtl/lru_block_cache_core.sv @@
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                                 | tuser
// in_     | in  | key[31:0], data_in[95:32]                          | op[1:0]
// out_    | out | hit, data_out, evicted, evicted_key, entry_count  | -
//
// One request per cycle sustained while out_tready is high; a request passes
// the input register, then the result register after the parallel tag compare.
// Reset clears valid bits, ranks and count at once; no clearing pass.
// A stalled result holds the result register; the input register keeps
// taking one request behind it, then in_tready drops.
module lru_block_cache_core
  import lbc_pkg::*;
#(
  parameter int CAPACITY    = 8,
  parameter int BLOCK_BYTES = 8,
  parameter int KEY_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key[31:0], data_in[95:32]
  input  logic [1:0]   in_tuser,   // op[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // hit[0], data_out[64:1], evicted[65],
                                   // evicted_key[97:66], entry_count[101:98]
);

  logic in_vld_r;
  req_t in_req_r;
  logic out_vld_r;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r.op      <= in_tuser;
      in_req_r.key     <= in_tdata[31:0];
      in_req_r.data_in <= in_tdata[95:32];
    end
    if (adv) begin
      out_rsp_r <= rsp;
    end
  end

  lbc_engine #(
    .CAPACITY    (CAPACITY),
    .BLOCK_BYTES (BLOCK_BYTES),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (adv),
    .req     (in_req_r),
    .rsp     (rsp)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_rsp_r};

endmodule

@@ rtl/lbc_engine.sv @@
`timescale 1ns / 1ps
`include "lru_block_cache_core_defines.svh"
module lbc_engine
  import lbc_pkg::*;
#(
  parameter int CAPACITY    = 8,
  parameter int BLOCK_BYTES = 8,
  parameter int KEY_WIDTH   = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_vld,
  input  req_t req,
  output rsp_t rsp
);

  localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
  localparam int DW = BLOCK_BYTES * 8;
  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KW-1:0]       entry_key_r  [CAPACITY];
  logic [DW-1:0]       entry_data_r [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [RW-1:0]       rank_r       [CAPACITY];
  logic [RW-1:0]       rank_nxt     [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;

  logic [KW-1:0]       key_w;
  logic [CAPACITY-1:0] match, sel, free_oh, victim_oh, ins_oh;
  logic                any_hit, full, free_found;
  logic [RW-1:0]       rank_s;
  logic [DW-1:0]       rd_data;
  logic [KW-1:0]       ev_key;
  logic [7:0]          cnt_ext;

  assign key_w = req.key[KW-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (entry_key_r[i] == key_w);
    end
    // most recent match wins
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i] = match[i];
      for (int j = 0; j < CAPACITY; j++) begin
        if (j != i && match[j] && (rank_r[j] < rank_r[i])) begin
          sel[i] = 1'b0;
        end
      end
    end
    any_hit = |match;
    rank_s  = '0;
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        rank_s  = rank_s | rank_r[i];
        rd_data = rd_data | entry_data_r[i];
      end
    end

    full       = (count_r >= CW'(CAPACITY));
    free_oh    = '0;
    free_found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!valid_r[i] && !free_found) begin
        free_oh[i] = 1'b1;
        free_found = 1'b1;
      end
    end
    ev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      victim_oh[i] = valid_r[i] && (rank_r[i] == RW'(CAPACITY - 1));
      if (victim_oh[i]) begin
        ev_key = ev_key | entry_key_r[i];
      end
    end
    ins_oh = full ? victim_oh : free_oh;

    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    unique case (req.op)
      OP_LOOKUP: begin
      end
      OP_TOUCH: begin
        if (any_hit) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (sel[i]) begin
              rank_nxt[i] = '0;
            end else if (valid_r[i] && (rank_r[i] < rank_s)) begin
              rank_nxt[i] = rank_r[i] + 1'b1;
            end
          end
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (ins_oh[i]) begin
            rank_nxt[i]  = '0;
            valid_nxt[i] = 1'b1;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        if (!full) begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        valid_nxt = '0;
        count_nxt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
          rank_nxt[i] = '0;
        end
      end
    endcase

    cnt_ext          = 8'(count_nxt);
    rsp.hit          = (req.op == OP_LOOKUP || req.op == OP_TOUCH) && any_hit;
    rsp.data_out     = rsp.hit ? DATA_BITS'(rd_data) : '0;
    rsp.evicted      = (req.op == OP_INSERT) && full;
    rsp.evicted_key  = rsp.evicted ? KEY_BITS'(ev_key) : '0;
    rsp.entry_count  = cnt_ext[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (req_vld) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (req_vld && (req.op == OP_INSERT) && ins_oh[i]) begin
        entry_key_r[i]  <= key_w;
        entry_data_r[i] <= req.data_in[DW-1:0];
      end
    end
  end

  `LBC_ASSERT(a_count_max, count_r <= CW'(CAPACITY), "entry count above capacity")
  `LBC_ASSERT(a_count_valid, $countones(valid_r) == count_r, "count out of step with valid bits")
  `LBC_ASSERT(a_clear, req_vld && req.op == OP_CLEAR |=> count_r == '0, "clear left entries")
  `LBC_ASSERT_ALWAYS(a_reset, !rst_n |=> count_r == '0 && valid_r == '0, "reset left entries")

endmodule
